>>> src/tdws_pkg.sv
// Shared types and constants of the task dependency wake scoreboard.
package tdws_pkg;

  // Default number of tracked modules
  localparam int ModuleCountDef = 16;
  // Upper bound on wake results reported for one finish request
  localparam int MaxResults = 16;
  // Entries of the queue between front and back
  localparam int QueueDepth = 2;

  // Field widths fixed by the channel definition
  localparam int ModeW = 1;
  localparam int IdW   = 4;
  localparam int DepW  = 16;
  localparam int KindW = 2;

  // Request modes
  localparam logic [ModeW-1:0] ModeWait   = 1'b0;
  localparam logic [ModeW-1:0] ModeFinish = 1'b1;

  // Result kinds
  localparam logic [KindW-1:0] KindSleep     = 2'd0;
  localparam logic [KindW-1:0] KindSatisfied = 2'd1;
  localparam logic [KindW-1:0] KindWake      = 2'd2;

  // One classified request as it travels through the queue
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   module_id;
    logic [DepW-1:0]  dependency_set;
  } tdws_item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } tdws_qstat_t;

endpackage

>>> src/tdws_front.sv
// Front end: accepts requests, drops out-of-range ids, pushes the rest into the queue.
module tdws_front #(
  parameter int MODULE_COUNT = tdws_pkg::ModuleCountDef
) (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [tdws_pkg::ModeW-1:0] mode_i,
  input  logic [tdws_pkg::IdW-1:0]   module_id_i,
  input  logic [tdws_pkg::DepW-1:0]  dependency_set_i,
  input  tdws_pkg::tdws_qstat_t    qstat_i,
  output logic                     push_o,
  output tdws_pkg::tdws_item_t     item_o
);

  logic accept;
  logic id_ok;

  // Stall only on a full queue
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Requests naming a module that does not exist cause nothing
  assign id_ok  = 32'(module_id_i) < MODULE_COUNT;
  assign push_o = accept && id_ok;

  assign item_o.mode           = mode_i;
  assign item_o.module_id      = module_id_i;
  assign item_o.dependency_set = dependency_set_i;

endmodule

>>> src/tdws_fifo.sv
// Short request queue between the front end and the back end.
module tdws_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tdws_pkg::tdws_item_t  item_i,
  input  logic                  pop_i,
  output tdws_pkg::tdws_item_t  item_o,
  output tdws_pkg::tdws_qstat_t qstat_o
);

  localparam int Depth = tdws_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  tdws_pkg::tdws_item_t    entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign qstat_o.full  = count_q == CntW'(Depth);
  assign qstat_o.empty = count_q == '0;
  assign item_o        = entry_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> src/tdws_back.sv
// Back end: row memory, armed flags, wait update and finish sweep with result register.
module tdws_back #(
  parameter int MODULE_COUNT = tdws_pkg::ModuleCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tdws_pkg::tdws_item_t        item_i,
  input  tdws_pkg::tdws_qstat_t       qstat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tdws_pkg::KindW-1:0]  kind_o,
  output logic [tdws_pkg::IdW-1:0]    target_module_o,
  output logic                        last_o
);

  localparam int RowW = MODULE_COUNT;
  localparam int IdxW = $clog2(MODULE_COUNT);
  localparam int CntW = $clog2(tdws_pkg::MaxResults + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWait  = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0] state_q, state_d;

  // Row memory, one row per module, registered read
  logic [RowW-1:0]         mem_q [MODULE_COUNT];
  logic [RowW-1:0]         rdata_q;
  logic                    rvld_q;
  logic [MODULE_COUNT-1:0] row_vld_q, row_vld_d;
  logic                    re, we;
  logic [IdxW-1:0]         raddr, waddr;
  logic [RowW-1:0]         wdata;

  logic [MODULE_COUNT-1:0] armed_q, armed_d;

  tdws_pkg::tdws_item_t    cur_q, cur_d;
  logic [IdxW-1:0]         ptr_q, ptr_d;
  logic                    held_vld_q, held_vld_d;
  logic [IdxW-1:0]         held_q, held_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  logic                       out_vld_q, out_vld_d;
  logic [tdws_pkg::KindW-1:0] out_kind_q, out_kind_d;
  logic [tdws_pkg::IdW-1:0]   out_tgt_q, out_tgt_d;
  logic                       out_last_q, out_last_d;
  logic                       out_load, out_free;

  logic [IdxW-1:0] cur_id;
  logic [RowW-1:0] row_eff, wait_row, fin_row;
  logic            wake;

  assign out_free = !out_vld_q || !out_stall_i;
  assign cur_id   = IdxW'(cur_q.module_id);
  // A row never written reads as all ones, since its valid flag stays clear after reset
  assign row_eff  = rvld_q ? rdata_q : '1;
  assign wait_row = row_eff & RowW'(cur_q.dependency_set);
  assign fin_row  = row_eff & ~(RowW'(1) << cur_id);
  assign wake     = armed_q[ptr_q] && (fin_row == '0) &&
                    (cnt_q < CntW'(tdws_pkg::MaxResults));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    ptr_d      = ptr_q;
    held_vld_d = held_vld_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    armed_d    = armed_q;
    row_vld_d  = row_vld_q;
    pop_o      = 1'b0;
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = ptr_q;
    wdata      = fin_row;
    out_load   = 1'b0;
    out_kind_d = out_kind_q;
    out_tgt_d  = out_tgt_q;
    out_last_d = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (!qstat_i.empty) begin
          pop_o      = 1'b1;
          cur_d      = item_i;
          re         = 1'b1;
          raddr      = (item_i.mode == tdws_pkg::ModeFinish) ? '0 : IdxW'(item_i.module_id);
          ptr_d      = '0;
          held_vld_d = 1'b0;
          cnt_d      = '0;
          state_d    = (item_i.mode == tdws_pkg::ModeFinish) ? StScan : StWait;
        end
      end
      StWait: begin
        // Narrow the waiter's row, arm it and report in one step
        if (out_free) begin
          we         = 1'b1;
          waddr      = cur_id;
          wdata      = wait_row;
          row_vld_d[cur_id] = 1'b1;
          armed_d[cur_id]   = 1'b1;
          out_load   = 1'b1;
          out_kind_d = (wait_row == '0) ? tdws_pkg::KindSatisfied : tdws_pkg::KindSleep;
          out_tgt_d  = cur_q.module_id;
          out_last_d = 1'b1;
          state_d    = StIdle;
        end
      end
      StScan: begin
        // One row per cycle unless a stall blocks a wake; the newest wake is held back until its last flag is known
        if (!(wake && held_vld_q && !out_free)) begin
          we    = 1'b1;
          waddr = ptr_q;
          wdata = fin_row;
          row_vld_d[ptr_q] = 1'b1;
          if (wake) begin
            if (held_vld_q) begin
              out_load   = 1'b1;
              out_kind_d = tdws_pkg::KindWake;
              out_tgt_d  = tdws_pkg::IdW'(held_q);
              out_last_d = 1'b0;
            end
            held_vld_d = 1'b1;
            held_d     = ptr_q;
            cnt_d      = cnt_q + 1'b1;
          end
          if (ptr_q == IdxW'(MODULE_COUNT - 1)) begin
            state_d = StFlush;
          end else begin
            ptr_d = ptr_q + 1'b1;
            re    = 1'b1;
            raddr = ptr_q + 1'b1;
          end
        end
      end
      StFlush: begin
        if (!held_vld_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = tdws_pkg::KindWake;
          out_tgt_d  = tdws_pkg::IdW'(held_q);
          out_last_d = 1'b1;
          held_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Result register
  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else begin
      out_vld_d = out_vld_q && out_stall_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ptr_q      <= '0;
      held_vld_q <= 1'b0;
      cnt_q      <= '0;
      armed_q    <= '0;
      row_vld_q  <= '0;
      rvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      held_vld_q <= held_vld_d;
      cnt_q      <= cnt_d;
      armed_q    <= armed_d;
      row_vld_q  <= row_vld_d;
      out_vld_q  <= out_vld_d;
      if (re) begin
        rvld_q <= row_vld_q[raddr];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    held_q     <= held_d;
    out_kind_q <= out_kind_d;
    out_tgt_q  <= out_tgt_d;
    out_last_q <= out_last_d;
  end

  // Row memory ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = out_kind_q;
  assign target_module_o = out_tgt_q;
  assign last_o          = out_last_q;

endmodule

>>> src/task_dependency_wake_scoreboard_core.sv
// Top level of the task dependency wake scoreboard.
//
// Input channel (in_valid_i / in_stall_o): one request per accepted cycle.
// mode_i = 0 is a wait request: dependency_set_i is ANDed into the row of
// module_id_i and that module is armed; it yields one result, kind sleep or
// satisfied, with last_o set. mode_i = 1 is a finish request: the column of
// module_id_i is cleared in every row, then every armed module whose row is
// empty is reported as a wake result, lowest index first, last_o on the final
// one; a finish with nothing ready yields no result. Ids at or above
// MODULE_COUNT are accepted and dropped.
// Output channel (out_valid_o / out_stall_i): one result register.
// A finish request occupies the back end for a sweep that reads and rewrites
// one row of the row memory per cycle unless a stalled result blocks a wake.
// A two-entry queue lets requests be accepted while the back end works.
// A stalled receiver holds the result and freezes the sweep when a further
// wake is due; in_stall_o rises once the queue fills. After reset all rows
// read as fully pending and no module is armed; no clearing pass is needed.
module task_dependency_wake_scoreboard_core #(
  parameter int MODULE_COUNT = tdws_pkg::ModuleCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tdws_pkg::ModeW-1:0]  mode_i,
  input  logic [tdws_pkg::IdW-1:0]    module_id_i,
  input  logic [tdws_pkg::DepW-1:0]   dependency_set_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tdws_pkg::KindW-1:0]  kind_o,
  output logic [tdws_pkg::IdW-1:0]    target_module_o,
  output logic                        last_o
);

  tdws_pkg::tdws_item_t  push_item;
  tdws_pkg::tdws_item_t  pop_item;
  tdws_pkg::tdws_qstat_t qstat;
  logic                  push;
  logic                  pop;

  // Request intake
  tdws_front #(
    .MODULE_COUNT(MODULE_COUNT)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .module_id_i     (module_id_i),
    .dependency_set_i(dependency_set_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .item_o          (push_item)
  );

  // Decoupling queue
  tdws_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .qstat_o(qstat)
  );

  // Scoreboard state and result generation
  tdws_back #(
    .MODULE_COUNT(MODULE_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (pop_item),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .target_module_o(target_module_o),
    .last_o         (last_o)
  );

endmodule

>>> src/tdws_checker.sv
// Port-level checker for the scoreboard and its bind to the top level.
module tdws_checker #(
  parameter int MODULE_COUNT = tdws_pkg::ModuleCountDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tdws_pkg::KindW-1:0] kind_o,
  input logic [tdws_pkg::IdW-1:0]   target_module_o,
  input logic                       last_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({kind_o, target_module_o, last_o}))
    else $error("result changed while stalled");

  // Wait requests always close with their single result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == tdws_pkg::KindSleep || kind_o == tdws_pkg::KindSatisfied)
    |-> last_o)
    else $error("wait result without last");

  // Only defined kinds, and targets that exist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == tdws_pkg::KindSleep || kind_o == tdws_pkg::KindSatisfied ||
                     kind_o == tdws_pkg::KindWake) &&
                    (32'(target_module_o) < MODULE_COUNT))
    else $error("bad result kind or target");

endmodule

bind task_dependency_wake_scoreboard_core tdws_checker #(
  .MODULE_COUNT(MODULE_COUNT)
) u_tdws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .target_module_o(target_module_o),
  .last_o         (last_o)
);

>>> sim/tb_task_dependency_wake_scoreboard_core.sv
// Self-checking testbench for the task dependency wake scoreboard core.
module tb_task_dependency_wake_scoreboard_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMOD  = tdws_pkg::ModuleCountDef;
  localparam int ModeW = tdws_pkg::ModeW;
  localparam int IdW   = tdws_pkg::IdW;
  localparam int DepW  = tdws_pkg::DepW;
  localparam int KindW = tdws_pkg::KindW;
  localparam logic [DepW-1:0] RowMask = DepW'((32'd1 << NMOD) - 32'd1);
  localparam int RandRequests = 300;
  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 2 * NMOD + 10;
  // Accepted-request window with no idling on either side
  localparam int QuietFrom = 60;
  localparam int QuietTo = 120;
  // Receiver hold-off that backs the block up
  localparam int HoldAt = 150;
  localparam int HoldCycles = 250;
  // Random request index after which the sender drains the block
  localparam int DrainAt = 180;

  // Pending request, or a pause marker that waits for all results
  typedef struct {
    tdws_pkg::tdws_item_t item;
    bit                   pause;
  } pending_t;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   target;
    logic             last;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ModeW-1:0]    mode_i = tdws_pkg::ModeWait;
  logic [IdW-1:0]      module_id_i = '0;
  logic [DepW-1:0]     dependency_set_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [KindW-1:0]    kind_o;
  logic [IdW-1:0]      target_module_o;
  logic                last_o;

  pending_t request_q[$];
  result_t  due_results[$];

  // Predicted scoreboard state
  logic [DepW-1:0] pend_row[NMOD];
  logic            armed[NMOD];

  int n_accepted = 0;
  int errors = 0;
  int cycles = 0;
  int pause_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_wait = 0;
  int n_finish = 0;
  int n_wake = 0;
  int max_wake = 0;
  int n_sleep = 0;

  wire quiet = (n_accepted >= QuietFrom) && (n_accepted < QuietTo);

  task_dependency_wake_scoreboard_core #(
    .MODULE_COUNT(NMOD)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .module_id_i      (module_id_i),
    .dependency_set_i (dependency_set_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .target_module_o  (target_module_o),
    .last_o           (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Update the scoreboard copy for one accepted request and queue its results
  task automatic apply_request(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                               input logic [DepW-1:0] deps);
    result_t r;
    int ready;
    int n;
    ready = 0;
    n = 0;
    if (int'(id) < NMOD) begin
      if (mode == tdws_pkg::ModeWait) begin
        n_wait++;
        pend_row[id] = pend_row[id] & deps & RowMask;
        armed[id] = 1'b1;
        r.kind = (pend_row[id] == '0) ? tdws_pkg::KindSatisfied : tdws_pkg::KindSleep;
        if (r.kind == tdws_pkg::KindSleep) n_sleep++;
        r.target = id;
        r.last = 1'b1;
        due_results.push_back(r);
      end else begin
        n_finish++;
        for (int i = 0; i < NMOD; i++) pend_row[i][id] = 1'b0;
        // Count first so the final wake can carry last
        for (int i = 0; i < NMOD; i++)
          if (armed[i] && pend_row[i] == '0 && ready < tdws_pkg::MaxResults) ready++;
        for (int i = 0; i < NMOD; i++) begin
          if (armed[i] && pend_row[i] == '0 && n < ready) begin
            r.kind = tdws_pkg::KindWake;
            r.target = IdW'(i);
            r.last = (n == ready - 1);
            due_results.push_back(r);
            n++;
          end
        end
        n_wake += ready;
        if (ready > max_wake) max_wake = ready;
      end
    end
  endtask

  task automatic queue_request(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                               input logic [DepW-1:0] deps);
    pending_t p;
    p.item.mode = mode;
    p.item.module_id = id;
    p.item.dependency_set = deps;
    p.pause = 1'b0;
    request_q.push_back(p);
  endtask

  function automatic bit check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Driver: offer queued requests, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    pending_t nxt;
    bit taken;
    bit go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      go = 1'b0;
      if (taken) begin
        apply_request(mode_i, module_id_i, dependency_set_i);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || taken) begin
        if (request_q.size() != 0) begin
          if (request_q[0].pause) begin
            // Hold off until the block has drained and settled
            if (due_results.size() == 0 && !in_valid_i) begin
              if (pause_cnt >= NMOD + 4) begin
                void'(request_q.pop_front());
                pause_cnt = 0;
              end else begin
                pause_cnt++;
              end
            end
          end else if (quiet || $urandom_range(0, 99) >= 7) begin
            nxt = request_q.pop_front();
            go = 1'b1;
          end
        end
        in_valid_i <= go;
        if (go) begin
          mode_i <= nxt.item.mode;
          module_id_i <= nxt.item.module_id;
          dependency_set_i <= nxt.item.dependency_set;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    result_t want;
    bit ok;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual kind %0d target %0d last %0d",
                   $realtime, kind_o, target_module_o, last_o);
        end else begin
          want = due_results.pop_front();
          ok = check_field("kind", want.kind, kind_o);
          ok = check_field("target_module", want.target, target_module_o) && ok;
          ok = check_field("last", want.last, last_o) && ok;
          if (!ok) errors++;
        end
      end
      if (!hold_done && n_accepted >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 7);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    pending_t marker;
    int n_rand;
    int waiter;
    int nfin;
    int b;
    logic [DepW-1:0] deps;

    for (int i = 0; i < NMOD; i++) begin
      pend_row[i] = RowMask;
      armed[i] = 1'b0;
    end

    // Directed: empty finish, full and empty sets, multi-wake finishes
    queue_request(tdws_pkg::ModeFinish, 4'd5, 16'h0000);
    queue_request(tdws_pkg::ModeWait, 4'd0, 16'hFFFF);
    queue_request(tdws_pkg::ModeWait, 4'd1, 16'h0020);
    queue_request(tdws_pkg::ModeFinish, 4'd7, 16'hFFFF);
    queue_request(tdws_pkg::ModeWait, 4'd2, 16'h0001);
    queue_request(tdws_pkg::ModeFinish, 4'd0, 16'h0000);
    queue_request(tdws_pkg::ModeWait, 4'd3, 16'h8000);
    queue_request(tdws_pkg::ModeWait, 4'd15, 16'h4000);
    queue_request(tdws_pkg::ModeFinish, 4'd14, 16'h0000);
    queue_request(tdws_pkg::ModeFinish, 4'd15, 16'h0000);
    queue_request(tdws_pkg::ModeWait, 4'd4, 16'hAAAA);
    queue_request(tdws_pkg::ModeWait, 4'd6, 16'h5555);
    queue_request(tdws_pkg::ModeWait, 4'd9, 16'h0000);
    queue_request(tdws_pkg::ModeFinish, 4'd1, 16'h1234);
    queue_request(tdws_pkg::ModeFinish, 4'd2, 16'h0000);
    queue_request(tdws_pkg::ModeWait, 4'd4, 16'hFFFF);
    queue_request(tdws_pkg::ModeFinish, 4'd9, 16'h0000);

    // Random: mostly wait-then-finish sequences, some noise
    n_rand = 0;
    while (n_rand < RandRequests) begin
      if ($urandom_range(0, 99) < 70) begin
        waiter = $urandom_range(0, NMOD - 1);
        case ($urandom_range(0, 4))
          0: deps = DepW'(1) << $urandom_range(0, DepW - 1);
          1: deps = DepW'($urandom & $urandom & $urandom);
          2: deps = DepW'($urandom);
          3: deps = '1;
          default: deps = '0;
        endcase
        queue_request(tdws_pkg::ModeWait, IdW'(waiter), deps);
        n_rand++;
        nfin = $urandom_range(0, 3);
        for (int k = 0; k < nfin; k++) begin
          // Finish one of the dependencies when there is one
          b = $urandom_range(0, DepW - 1);
          for (int s = 0; s < DepW && !deps[b]; s++) b = (b + 1) % DepW;
          queue_request(tdws_pkg::ModeFinish, IdW'(b), DepW'($urandom));
          n_rand++;
        end
      end else begin
        queue_request(ModeW'($urandom_range(0, 1)), IdW'($urandom_range(0, 15)),
                      DepW'($urandom));
        n_rand++;
      end
      if (n_rand >= DrainAt && n_rand < DrainAt + 4 && !marker.pause) begin
        marker.item = '0;
        marker.pause = 1'b1;
        request_q.push_back(marker);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all requests to be taken, then for the results
    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $realtime, due_results.size());
    end

    $display("Covered %0d requests: %0d waits (%0d sleeping), %0d finishes.",
             n_accepted, n_wait, n_sleep, n_finish);
    $display("Wakes reported: %0d, most from one finish: %0d; errors: %0d.",
             n_wake, max_wake, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
